### hw/rtl/same_pitch_note_off_filter_assert.svh
// Assertion macros for the same-pitch note-off filter.
`ifndef SAME_PITCH_NOTE_OFF_FILTER_ASSERT_SVH
`define SAME_PITCH_NOTE_OFF_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPNF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPNF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/spnf_pkg.sv
// Package: types, widths and defaults of the same-pitch note-off filter.
package spnf_pkg;

	localparam int OP_W        = 3;
	localparam int PITCH_W     = 7;
	localparam int HELD_W      = 8;
	localparam int NUM_PITCHES_DEF = 128;
	localparam int COUNT_BITS_DEF  = 8;

	typedef enum logic [OP_W-1:0] {
		OP_NOTE_ON    = 3'd0,
		OP_NOTE_OFF   = 3'd1,
		OP_ALL_OFF    = 3'd2,
		OP_OTHER      = 3'd3,
		OP_IDLE_CLEAR = 3'd4
	} op_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} store_ctl_t;

	typedef struct packed {
		logic wr_en;
		logic clr;
		logic deliver;
		logic has_result;
	} upd_t;

endpackage

### hw/rtl/spnf_if.sv
// Channel interfaces: input event and result.
interface spnf_ev_if
	import spnf_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [PITCH_W-1:0] pitch;

	modport source (output valid, output operation, output pitch, input ready);
	modport sink   (input valid, input operation, input pitch, output ready);
endinterface

interface spnf_res_if
	import spnf_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              deliver;
	logic [HELD_W-1:0] held_count;

	modport source (output valid, output deliver, output held_count, input ready);
	modport sink   (input valid, input deliver, input held_count, output ready);
endinterface

### hw/rtl/spnf_store.sv
// Hold counter store: memory, per-entry valid bits, registered read with write forwarding.
module spnf_store
	import spnf_pkg::*;
#(
	parameter int NUM_PITCHES = NUM_PITCHES_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF,
	localparam int IDX_W = (NUM_PITCHES > 1) ? $clog2(NUM_PITCHES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  store_ctl_t            ctl,
	input  logic [IDX_W-1:0]      rd_idx,
	input  logic [IDX_W-1:0]      wr_idx,
	input  logic [COUNT_BITS-1:0] wr_cnt,
	output logic [COUNT_BITS-1:0] rd_cnt
);

	logic [COUNT_BITS-1:0] mem [NUM_PITCHES];
	logic [NUM_PITCHES-1:0] valid_q;
	logic [COUNT_BITS-1:0] rd_q;
	logic [COUNT_BITS-1:0] byp_cnt_q;
	logic                  zero_q;
	logic                  byp_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_idx] <= wr_cnt;
		end
		if (ctl.rd_en) begin
			rd_q      <= mem[rd_idx];
			byp_cnt_q <= wr_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b1;
			byp_q  <= 1'b0;
		end else if (ctl.rd_en) begin
			zero_q <= ctl.clr || !valid_q[rd_idx];
			byp_q  <= ctl.wr_en && (wr_idx == rd_idx);
		end
	end

	// forwarded write wins over stale array data; clear or unwritten reads as zero
	assign rd_cnt = byp_q ? byp_cnt_q : (zero_q ? '0 : rd_q);

endmodule

### hw/rtl/spnf_update.sv
// Counter update and pass/strip decision for one event.
module spnf_update
	import spnf_pkg::*;
#(
	parameter int NUM_PITCHES = NUM_PITCHES_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic [OP_W-1:0]       operation,
	input  logic [PITCH_W-1:0]    pitch,
	input  logic [COUNT_BITS-1:0] cnt,
	output upd_t                  upd,
	output logic [COUNT_BITS-1:0] new_cnt,
	output logic [HELD_W-1:0]     held_count
);

	localparam logic [PITCH_W:0] NP = (PITCH_W+1)'(NUM_PITCHES);

	logic in_range;

	assign in_range = ({1'b0, pitch} < NP);

	always_comb begin
		upd        = '0;
		new_cnt    = cnt;
		held_count = '0;
		upd.deliver    = 1'b1;
		upd.has_result = 1'b1;
		case (op_t'(operation))
			OP_NOTE_ON: begin
				if (in_range) begin
					new_cnt    = (cnt == '1) ? cnt : cnt + COUNT_BITS'(1);
					upd.wr_en  = 1'b1;
					held_count = HELD_W'(new_cnt);
				end
			end
			OP_NOTE_OFF: begin
				if (in_range) begin
					new_cnt     = (cnt == '0) ? cnt : cnt - COUNT_BITS'(1);
					upd.wr_en   = 1'b1;
					held_count  = HELD_W'(new_cnt);
					upd.deliver = (new_cnt == '0);
				end
			end
			OP_ALL_OFF: begin
				upd.clr = 1'b1;
			end
			OP_IDLE_CLEAR: begin
				upd.clr        = 1'b1;
				upd.has_result = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

### hw/rtl/same_pitch_note_off_filter.sv
// A result is valid once its event has passed the store read register, then the output register.
// Throughput: one event per cycle without stalls; the store is one read and one write port memory.
// Back-to-back events on the same pitch see the previous update through write forwarding.
// Reset: all hold counters read as zero at once through per-pitch valid bits; no clearing pass.
// All-off and idle-clear clear every counter at once.
`include "same_pitch_note_off_filter_assert.svh"

module same_pitch_note_off_filter
	import spnf_pkg::*;
#(
	parameter int NUM_PITCHES = NUM_PITCHES_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	spnf_ev_if.sink    ev,
	spnf_res_if.source res
);

	localparam int IDX_W = (NUM_PITCHES > 1) ? $clog2(NUM_PITCHES) : 1;

	logic                  valid_s1;
	logic [OP_W-1:0]       op_s1;
	logic [PITCH_W-1:0]    pitch_s1;
	logic                  valid_s2;
	logic                  deliver_s2;
	logic [HELD_W-1:0]     held_s2;

	logic                  adv;
	logic                  accept;
	store_ctl_t            ctl;
	upd_t                  upd;
	logic [COUNT_BITS-1:0] cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	logic [HELD_W-1:0]     held_count;

	assign adv      = !valid_s2 || res.ready;
	assign ev.ready = !valid_s1 || adv;
	assign accept   = ev.valid && ev.ready;

	assign ctl.rd_en = accept;
	assign ctl.wr_en = valid_s1 && adv && upd.wr_en;
	assign ctl.clr   = valid_s1 && adv && upd.clr;

	spnf_store #(
		.NUM_PITCHES (NUM_PITCHES),
		.COUNT_BITS  (COUNT_BITS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rd_idx (ev.pitch[IDX_W-1:0]),
		.wr_idx (pitch_s1[IDX_W-1:0]),
		.wr_cnt (new_cnt),
		.rd_cnt (cnt)
	);

	spnf_update #(
		.NUM_PITCHES (NUM_PITCHES),
		.COUNT_BITS  (COUNT_BITS)
	) u_update (
		.operation  (op_s1),
		.pitch      (pitch_s1),
		.cnt        (cnt),
		.upd        (upd),
		.new_cnt    (new_cnt),
		.held_count (held_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ev.ready) begin
				valid_s1 <= ev.valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1 && upd.has_result;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= ev.operation;
			pitch_s1 <= ev.pitch;
		end
		if (adv && valid_s1) begin
			deliver_s2 <= upd.deliver;
			held_s2    <= held_count;
		end
	end

	assign res.valid      = valid_s2;
	assign res.deliver    = deliver_s2;
	assign res.held_count = held_s2;

	`SPNF_ASSERT_IMP(a_strip_nonzero, clk, arst_n, valid_s1 && !upd.deliver, new_cnt != '0, "stripped event with zero count")
	`SPNF_ASSERT_NXT(a_idle_no_result, clk, arst_n, valid_s1 && adv && op_s1 == OP_IDLE_CLEAR, !valid_s2, "idle clear produced a result")
	`SPNF_ASSERT_NXT(a_clear_fwd, clk, arst_n, ctl.clr && accept, cnt == '0, "count survived a clear")
	`SPNF_ASSERT_IMP(a_ready_free, clk, arst_n, !valid_s2, ev.ready, "input stalled with empty output")

endmodule
